@@ rtl/ptic_pkg.sv @@
// Shared types and constants for the PPM to iBus converter.
package ptic_pkg;

  localparam int unsigned PPM_CHANNELS  = 10;
  localparam int unsigned IBUS_CHANNELS = 14;
  localparam int unsigned FRAME_BYTES   = 32;

  localparam int unsigned SLOT_W = $clog2(PPM_CHANNELS + 1);
  localparam int unsigned CHAN_W = $clog2(IBUS_CHANNELS);
  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES);

  localparam logic [15:0] THRESH_RESET = 16'd5000;
  localparam logic [7:0]  FRAME_LEN    = 8'h20;
  localparam logic [7:0]  FRAME_CMD    = 8'h40;
  localparam logic [15:0] CSUM_INIT    = 16'hffff;
  localparam logic [14:0] VAL_DEFAULT  = 15'd1500;
  localparam logic [14:0] VAL_MIN      = 15'd900;

  // Byte positions inside a frame
  localparam logic [CNT_W-1:0] POS_LEN     = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_CMD     = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_CSUM_LO = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_CSUM_HI = CNT_W'(FRAME_BYTES - 1);

  // One queued operation: a falling-edge event or a frame request
  typedef struct packed {
    logic        is_frame;
    logic [15:0] ts;
  } ptic_op_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ptic_status_t;

  function automatic logic [14:0] chan_reset_val(input int unsigned idx);
    if (idx == 0 || idx == 1 || idx == 3 || idx == IBUS_CHANNELS - 1) begin
      return VAL_DEFAULT;
    end
    return VAL_MIN;
  endfunction

endpackage

@@ rtl/ptic_front.sv @@
// Front end: accepts input beats, drops ignored pin events, queues the rest.
module ptic_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic              pin_level_i,
  input  logic [15:0]       timestamp_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output ptic_pkg::ptic_op_t op_o
);
  import ptic_pkg::*;

  ptic_op_t   mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = mem_q[rptr_q];

  // A rising level is a no-op; it is accepted but never queued.
  assign push = in_valid_i && in_ready_o && (cmd_i || !pin_level_i);
  assign pop  = op_valid_o && op_ready_i;

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{is_frame: cmd_i, ts: timestamp_i};
    end
  end

endmodule

@@ rtl/ptic_back.sv @@
// Back end: PPM slot capture and iBus frame serializer with output register.
module ptic_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           sync_threshold_i,
  input  logic                  op_valid_i,
  output logic                  op_ready_o,
  input  ptic_pkg::ptic_op_t    op_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output ptic_pkg::ptic_status_t status_o
);
  import ptic_pkg::*;

  logic [15:0]       edge_q, edge_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [14:0]       capture_q [PPM_CHANNELS];
  logic [14:0]       capture_d [PPM_CHANNELS];
  logic [14:0]       staged_q  [PPM_CHANNELS];
  logic [14:0]       staged_d  [PPM_CHANNELS];
  logic              staged_rdy_q, staged_rdy_d;
  logic [14:0]       chan_q [IBUS_CHANNELS];
  logic [14:0]       chan_d [IBUS_CHANNELS];

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       sum_q, sum_d;
  logic              oval_q, oval_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              olast_q, olast_d;

  logic              pop, emit, in_range;
  logic [15:0]       pulse;
  logic [CHAN_W-1:0] ch_idx;
  logic [14:0]       ch_val;
  logic [7:0]        byte_sel;

  assign op_ready_o  = !busy_q;
  assign pop         = op_valid_i && op_ready_o;
  assign emit        = busy_q && (!oval_q || out_ready_i);
  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;
  assign status_o    = '{busy: busy_q, count: cnt_q};

  assign pulse    = op_i.ts - edge_q;
  assign in_range = (slot_q < SLOT_W'(PPM_CHANNELS));

  // Channel bytes sit at positions 2..29, two per channel
  assign ch_idx = CHAN_W'(cnt_q[CNT_W-1:1] - 4'd1);
  assign ch_val = (ch_idx < CHAN_W'(IBUS_CHANNELS)) ? chan_q[ch_idx] : '0;

  always_comb begin
    case (cnt_q)
      POS_LEN:     byte_sel = FRAME_LEN;
      POS_CMD:     byte_sel = FRAME_CMD;
      POS_CSUM_LO: byte_sel = sum_q[7:0];
      POS_CSUM_HI: byte_sel = sum_q[15:8];
      default:     byte_sel = cnt_q[0] ? {1'b0, ch_val[14:8]} : ch_val[7:0];
    endcase
  end

  always_comb begin
    edge_d       = edge_q;
    slot_d       = slot_q;
    capture_d    = capture_q;
    staged_d     = staged_q;
    staged_rdy_d = staged_rdy_q;
    chan_d       = chan_q;
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    oval_d       = oval_q && !out_ready_i;
    obyte_d      = obyte_q;
    olast_d      = olast_q;

    if (pop) begin
      if (op_i.is_frame) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        sum_d  = CSUM_INIT;
      end else begin
        edge_d = op_i.ts;
        if (pulse > sync_threshold_i && in_range) begin
          // sync gap: restart slots, stage a snapshot if none pending
          slot_d = '0;
          if (!staged_rdy_q) begin
            staged_d     = capture_q;
            staged_rdy_d = 1'b1;
          end
        end else if (in_range) begin
          capture_d[slot_q[SLOT_W-1:0]] = pulse[15:1];
          slot_d = slot_q + SLOT_W'(1);
        end else begin
          slot_d = '0;
        end
      end
    end

    if (emit) begin
      oval_d  = 1'b1;
      obyte_d = byte_sel;
      olast_d = (cnt_q == POS_CSUM_HI);
      cnt_d   = cnt_q + CNT_W'(1);
      if (cnt_q < POS_CSUM_LO) begin
        sum_d = sum_q - {8'd0, byte_sel};
      end
      if (cnt_q == POS_CSUM_HI) begin
        busy_d = 1'b0;
        if (staged_rdy_q) begin
          for (int i = 0; i < PPM_CHANNELS; i++) begin
            chan_d[i] = staged_q[i];
          end
          staged_rdy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q       <= '0;
      slot_q       <= '0;
      staged_rdy_q <= 1'b0;
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      oval_q       <= 1'b0;
      for (int i = 0; i < PPM_CHANNELS; i++) begin
        capture_q[i] <= VAL_MIN;
      end
      for (int i = 0; i < IBUS_CHANNELS; i++) begin
        chan_q[i] <= chan_reset_val(i);
      end
    end else begin
      edge_q       <= edge_d;
      slot_q       <= slot_d;
      staged_rdy_q <= staged_rdy_d;
      busy_q       <= busy_d;
      cnt_q        <= cnt_d;
      oval_q       <= oval_d;
      capture_q    <= capture_d;
      chan_q       <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    staged_q <= staged_d;
    sum_q    <= sum_d;
    obyte_q  <= obyte_d;
    olast_q  <= olast_d;
  end

endmodule

@@ rtl/ppm_to_ibus_converter.sv @@
// Top level of the PPM to iBus converter: config register, front end, back end.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid_i/in_ready_o, cmd_i, pin_level_i, | pin event or frame request
//          | timestamp_i                               |
//  out     | out_valid_o/out_ready_i, out_byte_o,      | one iBus byte, last on
//          | last_o                                    | checksum high byte
//  cfg     | cfg_we_i, cfg_wdata_i                     | sync threshold write
//
// A frame request goes out as 32 bytes, one byte per cycle through the output register
// while out_ready_i is high, set by the byte counter of the back end.
// A two-entry queue lets inputs be taken while a frame is still going out.
// Reset restores the threshold, slots and channel defaults at once; no clearing pass.
// Output stalls freeze the byte counter; the queue fills and then drops in_ready_o.
module ppm_to_ibus_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic        pin_level_i,
  input  logic [15:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import ptic_pkg::*;

  logic [15:0]  thresh_q;
  logic         op_valid, op_ready;
  ptic_op_t     op;
  ptic_status_t st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  ptic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .pin_level_i (pin_level_i),
    .timestamp_i (timestamp_i),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op)
  );

  ptic_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sync_threshold_i (thresh_q),
    .op_valid_i       (op_valid),
    .op_ready_o       (op_ready),
    .op_i             (op),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .status_o         (st)
  );

  // Full queue means there is work waiting for the back end
  a_full_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> op_valid)
    else $error("queue full but no op offered");

  // A stalled output beat freezes the frame position
  a_stall_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.busy && out_valid_o && !out_ready_i |=> $stable(st.count))
    else $error("frame advanced during output stall");

  // Every frame starts at the header byte
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st.busy) |-> st.count == POS_LEN)
    else $error("frame started mid-stream");

  // The last flag only marks the checksum high byte
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && last_o |-> st.count == POS_LEN)
    else $error("last beat not at end of frame");

endmodule
